### src/two_layer_q_network_infer_train_unit_defines.svh
// Assertion macros used by the checker file
`ifndef TWO_LAYER_Q_NETWORK_INFER_TRAIN_UNIT_DEFINES_SVH
`define TWO_LAYER_Q_NETWORK_INFER_TRAIN_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset
`define TQN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset
`define TQN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked through reset as well
`define TQN_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/tqn_pkg.sv
package tqn_pkg;

  // Command codes carried on in_tuser
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_LOAD_CUR = 3'd1;
  localparam logic [2:0] CMD_LOAD_NXT = 3'd2;
  localparam logic [2:0] CMD_INFER = 3'd3;
  localparam logic [2:0] CMD_TRAIN = 3'd4;
  localparam logic [2:0] CMD_READ = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [1:0] REG_DISCOUNT = 2'd1;
  localparam logic [1:0] REG_ERR_CLIP = 2'd2;

  localparam logic [24:0] LEARN_RATE_RST = 25'd25166;
  localparam logic [24:0] DISCOUNT_RST = 25'd16441671;
  localparam logic [30:0] ERR_CLIP_RST = 31'd167772160;

  localparam int STATE_SIZE_DEF = 8;
  localparam int HIDDEN_SIZE_DEF = 32;

  localparam logic signed [40:0] QW_MAX = 41'sd2147483647;
  localparam logic signed [40:0] QW_MIN = -41'sd2147483648;
  localparam logic signed [32:0] SW_MAX = 33'sd2147483647;
  localparam logic signed [32:0] SW_MIN = -33'sd2147483648;

  typedef logic signed [31:0] q_t;
  typedef logic signed [64:0] prod_t;

  // Q8.24 product: drop 24 fraction bits (floor), saturate to 32 bits
  function automatic q_t q_mul(input prod_t p);
    logic signed [40:0] r;
    q_t res;
    r = p[64:24];
    if (r > QW_MAX) res = 32'sh7fffffff;
    else if (r < QW_MIN) res = 32'sh80000000;
    else res = r[31:0];
    return res;
  endfunction

  function automatic q_t sat33(input logic signed [32:0] s);
    q_t res;
    if (s > SW_MAX) res = 32'sh7fffffff;
    else if (s < SW_MIN) res = 32'sh80000000;
    else res = s[31:0];
    return res;
  endfunction

  function automatic q_t q_add(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic q_t q_sub(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

endpackage

### src/two_layer_q_network_infer_train_unit.sv
// Two-layer Q-network engine: inference and one-step SGD training.
// Input channel in_*: tuser carries the command, tdata the index, value,
// action and reward, tlast the episode-done flag. A transaction is taken
// when tvalid and tready are both high; tready is high only while idle.
// Write and load commands finish in the accepting cycle and give no result.
// Infer, train and read each give one result transaction on out_*.
// All parameters sit in one RAM with a registered read port and a separate
// write port; one shared multiplier and a small sequencer walk every
// product, one RAM read per multiply-accumulate. With S = STATE_SIZE and
// H = HIDDEN_SIZE, the commands run:
//   read  : a RAM read, then the result register
//   infer : one forward pass of H*S hidden and 2*H output MACs
//   train : two forward passes, then updates the taken action's H output
//           weights and bias, then H*S hidden weights and H hidden biases
// Reset (synchronous, rst_n low) restores the configuration registers and
// empties the result register; parameters and state vectors are not
// cleared and must be written before use. A stalled receiver holds the
// result in the output register; a later result waits. Configuration is
// written through cfg_we/cfg_index/cfg_wdata while idle, by the user; the block does not enforce it.
module two_layer_q_network_infer_train_unit
  import tqn_pkg::*;
#(
  parameter int STATE_SIZE = STATE_SIZE_DEF,
  parameter int HIDDEN_SIZE = HIDDEN_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // index[9:0], value[41:10], taken_action[42], reward[74:43], zero fill
  input  logic [79:0]  in_tdata,
  // cmd[2:0]
  input  logic [2:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // q_first[31:0], q_second[63:32], greedy_action[64], td_error[96:65],
  // squared_error[127:97], read_value[159:128]
  output logic [159:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_wdata
);

  localparam int W1_COUNT = HIDDEN_SIZE * STATE_SIZE;
  localparam int B1_BASE = W1_COUNT;
  localparam int W2_BASE = B1_BASE + HIDDEN_SIZE;
  localparam int B2_BASE = W2_BASE + 2 * HIDDEN_SIZE;
  localparam int PARAM_COUNT = B2_BASE + 2;
  localparam int AW = $clog2(PARAM_COUNT);
  localparam int IW = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
  localparam int JW = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;

  localparam logic [AW-1:0] B1_A = AW'(B1_BASE);
  localparam logic [AW-1:0] W2_A = AW'(W2_BASE);
  localparam logic [AW-1:0] B2_A = AW'(B2_BASE);
  localparam logic [AW-1:0] H_A = AW'(HIDDEN_SIZE);
  localparam logic [IW-1:0] I_LAST = IW'(HIDDEN_SIZE - 1);
  localparam logic [JW-1:0] J_LAST = JW'(STATE_SIZE - 1);

  // Sequencer states
  localparam logic [5:0] ST_IDLE = 6'd0;
  localparam logic [5:0] ST_F_Q0 = 6'd1;
  localparam logic [5:0] ST_F_Q0D = 6'd2;
  localparam logic [5:0] ST_F_Q1D = 6'd3;
  localparam logic [5:0] ST_F_HB = 6'd4;
  localparam logic [5:0] ST_F_HBD = 6'd5;
  localparam logic [5:0] ST_F_W1R = 6'd6;
  localparam logic [5:0] ST_F_W1M = 6'd7;
  localparam logic [5:0] ST_F_W1A = 6'd8;
  localparam logic [5:0] ST_F_RELU = 6'd9;
  localparam logic [5:0] ST_F_W2M = 6'd10;
  localparam logic [5:0] ST_F_W2A0 = 6'd11;
  localparam logic [5:0] ST_F_W2A1 = 6'd12;
  localparam logic [5:0] ST_F_END = 6'd13;
  localparam logic [5:0] ST_T_TGT = 6'd14;
  localparam logic [5:0] ST_T_TGT2 = 6'd15;
  localparam logic [5:0] ST_T_ERR = 6'd16;
  localparam logic [5:0] ST_T_SQ = 6'd17;
  localparam logic [5:0] ST_T_STEP = 6'd18;
  localparam logic [5:0] ST_T_STEPD = 6'd19;
  localparam logic [5:0] ST_T_W2R = 6'd20;
  localparam logic [5:0] ST_T_W2G = 6'd21;
  localparam logic [5:0] ST_T_W2H = 6'd22;
  localparam logic [5:0] ST_T_W2W = 6'd23;
  localparam logic [5:0] ST_T_B2R = 6'd24;
  localparam logic [5:0] ST_T_B2W = 6'd25;
  localparam logic [5:0] ST_T_GS = 6'd26;
  localparam logic [5:0] ST_T_GSD = 6'd27;
  localparam logic [5:0] ST_T_W1R = 6'd28;
  localparam logic [5:0] ST_T_W1M = 6'd29;
  localparam logic [5:0] ST_T_W1W = 6'd30;
  localparam logic [5:0] ST_T_B1R = 6'd31;
  localparam logic [5:0] ST_T_B1W = 6'd32;
  localparam logic [5:0] ST_R_RD = 6'd33;
  localparam logic [5:0] ST_R_RDD = 6'd34;
  localparam logic [5:0] ST_OUT = 6'd35;

  // Input field split
  logic [2:0]  in_cmd;
  logic [9:0]  in_idx;
  q_t          in_value;
  logic        in_act;
  q_t          in_reward;
  logic        in_acc;
  logic        in_idx_ok;

  assign in_cmd = in_tuser;
  assign in_idx = in_tdata[9:0];
  assign in_value = in_tdata[41:10];
  assign in_act = in_tdata[42];
  assign in_reward = in_tdata[74:43];
  assign in_acc = in_tvalid && in_tready;
  assign in_idx_ok = 32'(in_idx) < PARAM_COUNT;

  // Registers
  logic [5:0]     state_r, state_nxt;
  logic [2:0]     cmd_r;
  logic [AW-1:0]  idx_r;
  logic           idx_ok_r;
  logic           act_r;
  q_t             reward_r;
  logic           done_r;
  logic           pass_r;
  logic [IW-1:0]  i_r;
  logic [JW-1:0]  j_r;
  logic [AW-1:0]  w1a_r;
  q_t             acc_r, h_r, q0_r, q1_r, cq0_r, cq1_r;
  q_t             tgt_r, err_r, sq_r, step_r, gs_r, old_r, rd_r;
  prod_t          prod_r;
  logic [24:0]    lr_r, disc_r;
  logic [30:0]    clip_r;
  logic           out_valid_r;
  logic [159:0]   out_data_r;

  q_t s_cur_r [STATE_SIZE];
  q_t s_nxt_r [STATE_SIZE];
  q_t hid_r [HIDDEN_SIZE];
  q_t mem [PARAM_COUNT];
  q_t mem_rdata_r;

  logic [AW-1:0]   mem_raddr, mem_waddr, w2_addr;
  logic            mem_we;
  q_t              mem_wdata;
  logic signed [32:0] mul_a;
  q_t              mul_b;
  q_t              prod_q, s_sel, q_max, grad, err_raw, clip_pos, clip_neg;
  logic            i_last, j_last, res_load;

  assign in_tready = (state_r == ST_IDLE);
  assign prod_q = q_mul(prod_r);
  assign s_sel = pass_r ? s_nxt_r[j_r] : s_cur_r[j_r];
  assign q_max = (q1_r > q0_r) ? q1_r : q0_r;
  assign i_last = (i_r == I_LAST);
  assign j_last = (j_r == J_LAST);
  assign w2_addr = W2_A + (act_r ? H_A : '0) + AW'(i_r);
  assign grad = (hid_r[i_r] > 0) ? prod_q : '0;
  assign err_raw = q_sub(act_r ? cq1_r : cq0_r, tgt_r);
  assign clip_pos = {1'b0, clip_r};
  assign clip_neg = -clip_pos;
  assign res_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LEARN_RATE_RST;
      disc_r <= DISCOUNT_RST;
      clip_r <= ERR_CLIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARN_RATE: lr_r <= cfg_wdata[24:0];
        REG_DISCOUNT:   lr_r <= lr_r;
        default: ;
      endcase
      if (cfg_index == REG_DISCOUNT) disc_r <= cfg_wdata[24:0];
      if (cfg_index == REG_ERR_CLIP) clip_r <= cfg_wdata;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_F_W1M: begin
        mul_a = {mem_rdata_r[31], mem_rdata_r};
        mul_b = s_sel;
      end
      ST_F_W2M, ST_F_W2A0: begin
        mul_a = {mem_rdata_r[31], mem_rdata_r};
        mul_b = h_r;
      end
      ST_T_TGT: begin
        mul_a = {8'd0, disc_r};
        mul_b = q_max;
      end
      ST_T_SQ: begin
        mul_a = {err_r[31], err_r};
        mul_b = err_r;
      end
      ST_T_STEP: begin
        mul_a = {8'd0, lr_r};
        mul_b = err_r;
      end
      ST_T_W2G: begin
        mul_a = {err_r[31], err_r};
        mul_b = mem_rdata_r;
      end
      ST_T_W2H: begin
        mul_a = {step_r[31], step_r};
        mul_b = hid_r[i_r];
      end
      ST_T_GS: begin
        mul_a = {8'd0, lr_r};
        mul_b = hid_r[i_r];
      end
      ST_T_W1M: begin
        mul_a = {gs_r[31], gs_r};
        mul_b = s_cur_r[j_r];
      end
      default: ;
    endcase
  end

  // RAM address and write select
  always_comb begin
    mem_raddr = idx_r;
    mem_we = 1'b0;
    mem_waddr = w1a_r;
    mem_wdata = in_value;
    unique case (state_r)
      ST_IDLE: begin
        mem_we = in_acc && (in_cmd == CMD_WRITE) && in_idx_ok;
        mem_waddr = AW'(in_idx);
      end
      ST_F_Q0: mem_raddr = B2_A;
      ST_F_Q0D: mem_raddr = B2_A + AW'(1);
      ST_F_HB, ST_T_B1R: mem_raddr = B1_A + AW'(i_r);
      ST_F_W1R, ST_T_W1R: mem_raddr = w1a_r;
      ST_F_RELU: mem_raddr = W2_A + AW'(i_r);
      ST_F_W2M: mem_raddr = W2_A + H_A + AW'(i_r);
      ST_T_W2R: mem_raddr = w2_addr;
      ST_T_B2R: mem_raddr = B2_A + AW'(act_r);
      ST_T_W2W: begin
        mem_we = 1'b1;
        mem_waddr = w2_addr;
        mem_wdata = q_sub(old_r, prod_q);
      end
      ST_T_B2W: begin
        mem_we = 1'b1;
        mem_waddr = B2_A + AW'(act_r);
        mem_wdata = q_sub(mem_rdata_r, step_r);
      end
      ST_T_W1W: begin
        mem_we = 1'b1;
        mem_waddr = w1a_r;
        mem_wdata = q_sub(old_r, prod_q);
      end
      ST_T_B1W: begin
        mem_we = 1'b1;
        mem_waddr = B1_A + AW'(i_r);
        mem_wdata = q_sub(mem_rdata_r, gs_r);
      end
      default: ;
    endcase
  end

  // Parameter RAM
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_INFER || in_cmd == CMD_TRAIN) state_nxt = ST_F_Q0;
          else if (in_cmd == CMD_READ) state_nxt = ST_R_RD;
        end
      end
      ST_F_Q0:   state_nxt = ST_F_Q0D;
      ST_F_Q0D:  state_nxt = ST_F_Q1D;
      ST_F_Q1D:  state_nxt = ST_F_HB;
      ST_F_HB:   state_nxt = ST_F_HBD;
      ST_F_HBD:  state_nxt = ST_F_W1R;
      ST_F_W1R:  state_nxt = ST_F_W1M;
      ST_F_W1M:  state_nxt = ST_F_W1A;
      ST_F_W1A:  state_nxt = j_last ? ST_F_RELU : ST_F_W1R;
      ST_F_RELU: state_nxt = ST_F_W2M;
      ST_F_W2M:  state_nxt = ST_F_W2A0;
      ST_F_W2A0: state_nxt = ST_F_W2A1;
      ST_F_W2A1: state_nxt = i_last ? ST_F_END : ST_F_HB;
      ST_F_END: begin
        if (cmd_r == CMD_INFER) state_nxt = ST_OUT;
        else if (!pass_r) state_nxt = ST_F_Q0;
        else state_nxt = ST_T_TGT;
      end
      ST_T_TGT:   state_nxt = ST_T_TGT2;
      ST_T_TGT2:  state_nxt = ST_T_ERR;
      ST_T_ERR:   state_nxt = ST_T_SQ;
      ST_T_SQ:    state_nxt = ST_T_STEP;
      ST_T_STEP:  state_nxt = ST_T_STEPD;
      ST_T_STEPD: state_nxt = ST_T_W2R;
      ST_T_W2R:   state_nxt = ST_T_W2G;
      ST_T_W2G:   state_nxt = ST_T_W2H;
      ST_T_W2H:   state_nxt = ST_T_W2W;
      ST_T_W2W:   state_nxt = i_last ? ST_T_B2R : ST_T_W2R;
      ST_T_B2R:   state_nxt = ST_T_B2W;
      ST_T_B2W:   state_nxt = ST_T_GS;
      ST_T_GS:    state_nxt = ST_T_GSD;
      ST_T_GSD:   state_nxt = ST_T_W1R;
      ST_T_W1R:   state_nxt = ST_T_W1M;
      ST_T_W1M:   state_nxt = ST_T_W1W;
      ST_T_W1W:   state_nxt = j_last ? ST_T_B1R : ST_T_W1R;
      ST_T_B1R:   state_nxt = ST_T_B1W;
      ST_T_B1W:   state_nxt = i_last ? ST_OUT : ST_T_GS;
      ST_R_RD:    state_nxt = ST_R_RDD;
      ST_R_RDD:   state_nxt = ST_OUT;
      ST_OUT:     state_nxt = res_load ? ST_IDLE : ST_OUT;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_r <= in_cmd;
          idx_r <= AW'(in_idx);
          idx_ok_r <= in_idx_ok;
          act_r <= in_act;
          reward_r <= in_reward;
          done_r <= in_tlast;
          pass_r <= 1'b0;
          cq0_r <= '0;
          cq1_r <= '0;
          err_r <= '0;
          sq_r <= '0;
          rd_r <= '0;
          if (32'(in_idx) < STATE_SIZE) begin
            if (in_cmd == CMD_LOAD_CUR) s_cur_r[in_idx[JW-1:0]] <= in_value;
            if (in_cmd == CMD_LOAD_NXT) s_nxt_r[in_idx[JW-1:0]] <= in_value;
          end
        end
      end
      ST_F_Q0D: q0_r <= mem_rdata_r;
      ST_F_Q1D: begin
        q1_r <= mem_rdata_r;
        i_r <= '0;
        w1a_r <= '0;
      end
      ST_F_HBD: begin
        acc_r <= mem_rdata_r;
        j_r <= '0;
      end
      ST_F_W1A: begin
        acc_r <= q_add(acc_r, prod_q);
        w1a_r <= w1a_r + AW'(1);
        if (!j_last) j_r <= j_r + JW'(1);
      end
      ST_F_RELU: begin
        h_r <= (acc_r > 0) ? acc_r : '0;
        if (!pass_r) hid_r[i_r] <= (acc_r > 0) ? acc_r : '0;
      end
      ST_F_W2A0: q0_r <= q_add(q0_r, prod_q);
      ST_F_W2A1: begin
        q1_r <= q_add(q1_r, prod_q);
        if (!i_last) i_r <= i_r + IW'(1);
      end
      ST_F_END: begin
        if (!pass_r) begin
          cq0_r <= q0_r;
          cq1_r <= q1_r;
          pass_r <= 1'b1;
        end
      end
      ST_T_TGT2: tgt_r <= done_r ? reward_r : q_add(reward_r, prod_q);
      ST_T_ERR: begin
        if (err_raw > clip_pos) err_r <= clip_pos;
        else if (err_raw < clip_neg) err_r <= clip_neg;
        else err_r <= err_raw;
      end
      ST_T_STEP: sq_r <= prod_q;
      ST_T_STEPD: begin
        step_r <= prod_q;
        i_r <= '0;
      end
      ST_T_W2G: old_r <= mem_rdata_r;
      ST_T_W2H: hid_r[i_r] <= grad;
      ST_T_W2W: if (!i_last) i_r <= i_r + IW'(1);
      ST_T_B2W: begin
        i_r <= '0;
        w1a_r <= '0;
      end
      ST_T_GSD: begin
        gs_r <= prod_q;
        j_r <= '0;
      end
      ST_T_W1M: old_r <= mem_rdata_r;
      ST_T_W1W: begin
        w1a_r <= w1a_r + AW'(1);
        if (!j_last) j_r <= j_r + JW'(1);
      end
      ST_T_B1W: if (!i_last) i_r <= i_r + IW'(1);
      ST_R_RDD: rd_r <= idx_ok_r ? mem_rdata_r : '0;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= {rd_r, sq_r[30:0], err_r,
                     (cmd_r != CMD_READ) && (cq1_r > cq0_r), cq1_r, cq0_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule

### src/tqn_checker.sv
`include "two_layer_q_network_infer_train_unit_defines.svh"

module tqn_checker
  import tqn_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [2:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata
);

  logic busy_cmd;
  logic greedy_ok;

  assign busy_cmd = in_tvalid && in_tready &&
                    (in_tuser == CMD_INFER || in_tuser == CMD_TRAIN ||
                     in_tuser == CMD_READ);
  assign greedy_ok = $signed(out_tdata[63:32]) > $signed(out_tdata[31:0]);

  // Hold a stalled result
  `TQN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // Drop any result on reset
  `TQN_ASSERT_NEXT_NR(a_rst_empty, clk, !rst_n, !out_tvalid)
  // Stay busy after a computing command
  `TQN_ASSERT_NEXT(a_busy, clk, rst_n, busy_cmd, !in_tready)
  // Greedy flag only where the second Q wins
  `TQN_ASSERT_IMPL(a_greedy, clk, rst_n, out_tvalid && out_tdata[64], greedy_ok)

endmodule

bind two_layer_q_network_infer_train_unit tqn_checker u_tqn_checker (.*);
